// ===== src/assert_macros.svh =====
// assertion macros shared by the humidity reader modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWHR_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define SWHR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SWHR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SWHR_ASSERT(label, expr)
`define SWHR_ASSERT_IMPL(label, ante, cons)
`define SWHR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/swhr_pkg.sv =====
// types and constants of the single-wire humidity reader
// no dependencies
package swhr_pkg;

    localparam int START_W    = 20;
    localparam int DELAY_W    = 10;
    localparam int PAUSE_W    = 20;
    localparam int HUM_W      = 8;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_START_LOW    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_DELAY = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_LOW      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_HIGH     = 3'd4;

    localparam logic [START_W-1:0] START_LOW_RST    = 20'd20000;
    localparam logic [DELAY_W-1:0] SAMPLE_DELAY_RST = 10'd30;
    localparam logic [PAUSE_W-1:0] PAUSE_RST        = 20'd100000;
    localparam logic [HUM_W-1:0]   HUM_LOW_RST      = 8'd40;
    localparam logic [HUM_W-1:0]   HUM_HIGH_RST     = 8'd60;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_RESP_HIGH  = 4'd1,
        PH_RESP_LOW   = 4'd2,
        PH_RESP_HIGH2 = 4'd3,
        PH_BIT_RISE   = 4'd4,
        PH_BIT_DELAY  = 4'd5,
        PH_BIT_FALL   = 4'd6,
        PH_PAUSE      = 4'd7
    } phase_t;

    typedef struct packed {
        logic [START_W-1:0] start_low_ticks;
        logic [DELAY_W-1:0] sample_delay_ticks;
        logic [PAUSE_W-1:0] pause_ticks;
        logic [HUM_W-1:0]   humidity_low_limit;
        logic [HUM_W-1:0]   humidity_high_limit;
    } swhr_cfg_t;

    typedef struct packed {
        logic             alarm;
        logic [HUM_W-1:0] humidity;
        logic             reading_valid;
        logic             drive_low;
    } swhr_result_t;

endpackage

// ===== src/swhr_core.sv =====
// read sequencer: phase, tick and bit counters, shift register, held byte
// depends on swhr_pkg and assert_macros.svh
`include "assert_macros.svh"
module swhr_core #(
    parameter int DATA_BITS        = 8,
    parameter int TICK_COUNT_WIDTH = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   line_level,
    input  swhr_pkg::swhr_cfg_t    cfg,
    output swhr_pkg::swhr_result_t result
);
    import swhr_pkg::*;

    localparam int BIT_CNT_W = $clog2(DATA_BITS + 1);
    localparam int CMP_W     = (TICK_COUNT_WIDTH > START_W) ? TICK_COUNT_WIDTH : START_W;
    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(DATA_BITS);
    localparam logic [BIT_CNT_W-1:0] HUM_BITS = BIT_CNT_W'(HUM_W);

    phase_t                      phase_reg, phase_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_cnt_reg, tick_cnt_next;
    logic [BIT_CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [HUM_W-1:0]            shift_reg, shift_next;
    logic [HUM_W-1:0]            humidity_reg, humidity_next;
    logic                        alarm_reg, alarm_next;

    logic [TICK_COUNT_WIDTH-1:0] tick_inc;
    logic [CMP_W-1:0]            count_target;
    logic                        count_done;
    logic [BIT_CNT_W-1:0]        bit_inc;
    logic                        valid;

    // saturating tick counter, reaching the ceiling also ends a count
    always_comb
    begin
        tick_inc = (tick_cnt_reg == TICK_MAX) ? tick_cnt_reg : tick_cnt_reg + 1'b1;
        case (phase_reg)
            PH_START:     count_target = CMP_W'(cfg.start_low_ticks);
            PH_BIT_DELAY: count_target = CMP_W'(cfg.sample_delay_ticks);
            default:      count_target = CMP_W'(cfg.pause_ticks);
        endcase
        count_done = (CMP_W'(tick_inc) >= count_target) || (tick_inc == TICK_MAX);
        bit_inc    = bit_cnt_reg + 1'b1;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tick_cnt_next = tick_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        humidity_next = humidity_reg;
        alarm_next    = alarm_reg;
        valid         = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                tick_cnt_next = count_done ? '0 : tick_inc;
                if (count_done)
                    phase_next = PH_RESP_HIGH;
            end
            PH_RESP_HIGH:
            begin
                if (!line_level)
                    phase_next = PH_RESP_LOW;
            end
            PH_RESP_LOW:
            begin
                if (line_level)
                    phase_next = PH_RESP_HIGH2;
            end
            PH_RESP_HIGH2:
            begin
                if (!line_level)
                begin
                    bit_cnt_next = '0;
                    phase_next   = PH_BIT_RISE;
                end
            end
            PH_BIT_RISE:
            begin
                if (line_level)
                begin
                    tick_cnt_next = '0;
                    phase_next    = PH_BIT_DELAY;
                end
            end
            PH_BIT_DELAY:
            begin
                tick_cnt_next = count_done ? '0 : tick_inc;
                if (count_done)
                begin
                    // only the humidity byte is kept, later bits pass through
                    if (bit_cnt_reg < HUM_BITS)
                        shift_next = {shift_reg[HUM_W-2:0], line_level};
                    phase_next = PH_BIT_FALL;
                end
            end
            PH_BIT_FALL:
            begin
                if (!line_level)
                begin
                    if (bit_inc >= BIT_LAST)
                    begin
                        humidity_next = shift_reg;
                        alarm_next    = (shift_reg < cfg.humidity_low_limit) ||
                                        (shift_reg > cfg.humidity_high_limit);
                        valid         = 1'b1;
                        bit_cnt_next  = '0;
                        tick_cnt_next = '0;
                        phase_next    = PH_PAUSE;
                    end
                    else
                    begin
                        bit_cnt_next = bit_inc;
                        phase_next   = PH_BIT_RISE;
                    end
                end
            end
            PH_PAUSE:
            begin
                tick_cnt_next = count_done ? '0 : tick_inc;
                if (count_done)
                    phase_next = PH_START;
            end
            default:
            begin
                phase_next    = PH_START;
                tick_cnt_next = '0;
                bit_cnt_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            tick_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            humidity_reg <= '0;
            alarm_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            tick_cnt_reg <= tick_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            humidity_reg <= humidity_next;
            alarm_reg    <= alarm_next;
        end
    end

    // drive_low follows the phase the tick was taken in
    assign result.drive_low     = (phase_reg == PH_START);
    assign result.reading_valid = valid;
    assign result.humidity      = humidity_next;
    assign result.alarm         = alarm_next;

    `SWHR_ASSERT(a_bit_cnt_range, bit_cnt_reg < BIT_LAST)
    `SWHR_ASSERT_IMPL(a_bit_cnt_idle, phase_reg == PH_START || phase_reg == PH_PAUSE,
        bit_cnt_reg == '0)
    `SWHR_ASSERT_IMPL(a_tick_cnt_edge_wait,
        phase_reg == PH_RESP_HIGH || phase_reg == PH_RESP_LOW ||
        phase_reg == PH_RESP_HIGH2 || phase_reg == PH_BIT_RISE ||
        phase_reg == PH_BIT_FALL, tick_cnt_reg == '0)

endmodule

// ===== src/single_wire_humidity_reader.sv =====
// top level of the single-wire humidity reader: config registers, output register
// depends on swhr_pkg, swhr_core and assert_macros.svh
//
// usage:
//   s_* carries one request per sensor tick; s_tdata[0] is the sampled line level.
//   m_* returns one result per request; m_tdata holds drive_low, reading_valid,
//   humidity and alarm. drive_low reports the start pulse for the tick taken.
//   cfg_we/cfg_addr/cfg_wdata write the timing and alarm registers, index 0..4;
//   other indexes are ignored. write only while no request is in flight.
// timing:
//   one request per cycle while the receiver does not stall; the result appears in
//   the output register in the cycle after the request is taken, set by the single
//   register stage after the sequencer update.
//   when the receiver stalls, the output register holds and s_tready drops
//   until the held result is taken; the sequencer only advances on a request.
// reset:
//   rst_n clears the sequencer to the start pulse phase, counters to zero,
//   held humidity and alarm to zero, and loads the default register values.
`include "assert_macros.svh"
module single_wire_humidity_reader #(
    parameter int DATA_BITS        = 8,
    parameter int TICK_COUNT_WIDTH = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] line_level
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] drive_low, [1] reading_valid, [9:2] humidity, [10] alarm
    output logic [swhr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [swhr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [swhr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import swhr_pkg::*;

    swhr_cfg_t                 cfg_reg;
    swhr_result_t              result;
    logic                      accept;
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks     <= START_LOW_RST;
            cfg_reg.sample_delay_ticks  <= SAMPLE_DELAY_RST;
            cfg_reg.pause_ticks         <= PAUSE_RST;
            cfg_reg.humidity_low_limit  <= HUM_LOW_RST;
            cfg_reg.humidity_high_limit <= HUM_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_START_LOW:    cfg_reg.start_low_ticks     <= cfg_wdata[START_W-1:0];
                REG_SAMPLE_DELAY: cfg_reg.sample_delay_ticks  <= cfg_wdata[DELAY_W-1:0];
                REG_PAUSE:        cfg_reg.pause_ticks         <= cfg_wdata[PAUSE_W-1:0];
                REG_HUM_LOW:      cfg_reg.humidity_low_limit  <= cfg_wdata[HUM_W-1:0];
                REG_HUM_HIGH:     cfg_reg.humidity_high_limit <= cfg_wdata[HUM_W-1:0];
                default:          ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    swhr_core #(
        .DATA_BITS        (DATA_BITS),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .line_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= OUT_DATA_W'(result);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SWHR_ASSERT_IMPL(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `SWHR_ASSERT_NEXT(a_request_gives_result, accept, m_tvalid)
    `SWHR_ASSERT_IMPL(a_valid_not_in_start, m_tvalid && m_tdata[1], !m_tdata[0])

endmodule
